[rtl/assert_macros.svh]
// Concurrent assertion helpers, clocked on clk and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define GPIO_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies the consequent in the next cycle.
`define GPIO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gpio_pkg.sv]
`timescale 1ns / 1ps

package gpio_pkg;

    localparam int unsigned WORD_W = 32;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_PIN   = 2'd2;

    localparam logic [4:0] REG_DR       = 5'd0;
    localparam logic [4:0] REG_DDR      = 5'd1;
    localparam logic [4:0] REG_CTL      = 5'd2;
    localparam logic [4:0] REG_INTEN    = 5'd3;
    localparam logic [4:0] REG_MASK     = 5'd4;
    localparam logic [4:0] REG_TYPE     = 5'd5;
    localparam logic [4:0] REG_POL      = 5'd6;
    localparam logic [4:0] REG_STATUS   = 5'd7;
    localparam logic [4:0] REG_RAW      = 5'd8;
    localparam logic [4:0] REG_DEBOUNCE = 5'd9;
    localparam logic [4:0] REG_EOI      = 5'd10;
    localparam logic [4:0] REG_EXT      = 5'd11;
    localparam logic [4:0] REG_SYNC     = 5'd12;
    localparam logic [4:0] REG_BOTHEDGE = 5'd14;

    typedef struct packed {
        logic [1:0]        mode;
        logic [4:0]        reg_index;
        logic [WORD_W-1:0] write_data;
        logic [4:0]        pin_index;
        logic              pin_level;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] read_data;
        logic [WORD_W-1:0] irq_lines;
        logic [WORD_W-1:0] pin_out_values;
        logic [WORD_W-1:0] pin_out_enable;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_out;
        logic [WORD_W-1:0] direction;
        logic [WORD_W-1:0] hw_control;
        logic [WORD_W-1:0] int_enable;
        logic [WORD_W-1:0] int_mask;
        logic [WORD_W-1:0] int_edge_type;
        logic [WORD_W-1:0] int_polarity_bits;
        logic [WORD_W-1:0] int_both_edge;
        logic [WORD_W-1:0] raw_status;
        logic [WORD_W-1:0] pin_levels;
        logic [WORD_W-1:0] debounce_bits;
        logic [WORD_W-1:0] level_sync;
    } state_t;

endpackage

[rtl/gpio_if.sv]
`timescale 1ns / 1ps

interface gpio_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic [4:0]  pin_index;
    logic        pin_level;

    modport source (output valid, output mode, output reg_index, output write_data,
                    output pin_index, output pin_level, input ready);
    modport sink   (input valid, input mode, input reg_index, input write_data,
                    input pin_index, input pin_level, output ready);
endinterface

interface gpio_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [31:0] irq_lines;
    logic [31:0] pin_out_values;
    logic [31:0] pin_out_enable;

    modport source (output valid, output read_data, output irq_lines,
                    output pin_out_values, output pin_out_enable, input ready);
    modport sink   (input valid, input read_data, input irq_lines,
                    input pin_out_values, input pin_out_enable, output ready);
endinterface

[rtl/gpio_core.sv]
`timescale 1ns / 1ps

module gpio_core #(
    parameter int unsigned PIN_COUNT = 32
) (
    input  gpio_pkg::state_t  state,
    input  gpio_pkg::item_t   item,
    output gpio_pkg::state_t  state_next,
    output gpio_pkg::result_t result
);
    import gpio_pkg::*;

    localparam logic [WORD_W-1:0] PIN_MASK = WORD_W'({WORD_W{1'b1}} >> (WORD_W - PIN_COUNT));

    logic [WORD_W-1:0] wval;
    logic [WORD_W-1:0] changed;
    logic [WORD_W-1:0] sel;
    logic [WORD_W-1:0] match;
    logic [WORD_W-1:0] rdata;
    logic              pin_ok;
    logic              prev_lvl;
    logic              active;
    state_t            n;

    assign wval   = item.write_data & PIN_MASK;
    assign pin_ok = {1'b0, item.pin_index} < 6'(PIN_COUNT);

    always_comb
    begin
        n        = state;
        rdata    = '0;
        changed  = '0;
        prev_lvl = state.pin_levels[item.pin_index];
        active   = item.pin_level == state.int_polarity_bits[item.pin_index];
        case (item.mode)
            MODE_READ:
            begin
                case (item.reg_index)
                    REG_DR:       rdata = state.data_out;
                    REG_DDR:      rdata = state.direction;
                    REG_CTL:      rdata = state.hw_control;
                    REG_INTEN:    rdata = state.int_enable;
                    REG_MASK:     rdata = state.int_mask;
                    REG_TYPE:     rdata = state.int_edge_type;
                    REG_POL:      rdata = state.int_polarity_bits;
                    REG_STATUS:   rdata = state.raw_status & ~state.int_mask;
                    REG_RAW:      rdata = state.raw_status;
                    REG_DEBOUNCE: rdata = state.debounce_bits;
                    REG_EXT:      rdata = (state.pin_levels & ~state.direction)
                                          | (state.data_out & state.direction);
                    REG_SYNC:     rdata = state.level_sync;
                    REG_BOTHEDGE: rdata = state.int_both_edge;
                    default:      rdata = '0;
                endcase
            end
            MODE_WRITE:
            begin
                case (item.reg_index)
                    REG_DR:       n.data_out = wval;
                    REG_DDR:
                    begin
                        n.direction = wval;
                        changed     = state.direction ^ wval;
                    end
                    REG_CTL:
                    begin
                        n.hw_control = wval;
                        changed      = state.hw_control ^ wval;
                    end
                    REG_INTEN:    n.int_enable = wval;
                    REG_MASK:     n.int_mask = wval;
                    REG_TYPE:     n.int_edge_type = wval;
                    REG_POL:      n.int_polarity_bits = wval;
                    REG_DEBOUNCE: n.debounce_bits = wval;
                    REG_EOI:      n.raw_status = state.raw_status & ~(wval & state.int_edge_type);
                    REG_SYNC:     n.level_sync = wval;
                    REG_BOTHEDGE: n.int_both_edge = wval;
                    default:      n = state;
                endcase
            end
            MODE_PIN:
            begin
                if (pin_ok)
                begin
                    n.pin_levels[item.pin_index] = item.pin_level;
                    if (!state.direction[item.pin_index] && !state.hw_control[item.pin_index])
                    begin
                        if (state.int_both_edge[item.pin_index])
                        begin
                            if (prev_lvl != item.pin_level)
                                n.raw_status[item.pin_index] = 1'b1;
                        end
                        else if (!state.int_edge_type[item.pin_index])
                            n.raw_status[item.pin_index] = active;
                        else if (prev_lvl != item.pin_level && active)
                            n.raw_status[item.pin_index] = 1'b1;
                    end
                end
            end
            default:      n = state;
        endcase
    end

    // level re-evaluation after a direction or control change
    assign sel   = changed & ~n.direction & ~n.hw_control & ~n.int_edge_type;
    assign match = ~(n.pin_levels ^ n.int_polarity_bits);

    always_comb
    begin
        state_next            = n;
        state_next.raw_status = ((n.raw_status & ~sel) | (match & sel)) & PIN_MASK;
    end

    assign result.read_data      = rdata;
    assign result.irq_lines      = state_next.raw_status & state_next.int_enable
                                   & ~state_next.int_mask;
    assign result.pin_out_values = state_next.data_out & state_next.direction;
    assign result.pin_out_enable = state_next.direction;

endmodule

[rtl/gpio_regs.sv]
`timescale 1ns / 1ps

module gpio_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  gpio_pkg::state_t state_next,
    output gpio_pkg::state_t state
);
    import gpio_pkg::*;

    state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (load)
            state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

[rtl/gpio_controller_with_interrupts.sv]
`timescale 1ns / 1ps
// A word accepted into the input stage is evaluated combinationally; its result is
// captured in the result register and offered on the result handshake from there.
// Throughput: one word per cycle unless rsp.ready holds a result; the input stage
// and result register advance together; intake stalls only when both stages are full.
// Reset: rst_n clears all GPIO state registers to zero and empties both stages.
`include "assert_macros.svh"

module gpio_controller_with_interrupts #(
    parameter int unsigned PIN_COUNT = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    gpio_req_if.sink   req,
    gpio_rsp_if.source rsp
);
    import gpio_pkg::*;

    item_t   item_reg;
    logic    item_vld_reg;
    result_t res_reg;
    logic    res_vld_reg;
    logic    advance;
    state_t  state;
    state_t  state_next;
    result_t result;

    assign advance   = !res_vld_reg || rsp.ready;
    assign req.ready = !item_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            if (req.ready)
                item_vld_reg <= req.valid;
            if (advance)
                res_vld_reg <= item_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            item_reg.mode       <= req.mode;
            item_reg.reg_index  <= req.reg_index;
            item_reg.write_data <= req.write_data;
            item_reg.pin_index  <= req.pin_index;
            item_reg.pin_level  <= req.pin_level;
        end
        if (advance && item_vld_reg)
            res_reg <= result;
    end

    gpio_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .state      (state),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result)
    );

    gpio_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && item_vld_reg),
        .state_next (state_next),
        .state      (state)
    );

    assign rsp.valid          = res_vld_reg;
    assign rsp.read_data      = res_reg.read_data;
    assign rsp.irq_lines      = res_reg.irq_lines;
    assign rsp.pin_out_values = res_reg.pin_out_values;
    assign rsp.pin_out_enable = res_reg.pin_out_enable;

    `GPIO_ASSERT_NEXT(a_item_held, clk, rst_n, item_vld_reg && !advance, item_vld_reg,
        "pending word lost while result stalled")
    `GPIO_ASSERT_NEXT(a_result_loaded, clk, rst_n, item_vld_reg && advance, res_vld_reg,
        "issued word produced no result")
    `GPIO_ASSERT(a_out_subset, clk, rst_n,
        !rsp.valid || ((rsp.pin_out_values & ~rsp.pin_out_enable) == '0),
        "driven value on a pin not in output direction")

endmodule
